// ----- design/fcrf_pkg.sv -----
// Shared types, constants and helpers for the framebuffer fill engine.
// No dependencies; the design files other than fcrf_ram use it by scoped names.
package fcrf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int CFG_W   = 9;
	localparam int COORD_W = 12;
	localparam int DELTA_W = 10;
	localparam int SQ_W    = 17;
	localparam int RR_W    = 18;
	localparam int CNT_W   = 17;
	localparam int COLOR_W = 32;
	localparam int IN_W    = 96;
	localparam int OUT_W   = 56;

	localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_BLACK  = 3'd1,
		OP_RECT   = 3'd2,
		OP_CIRCLE = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		K_FILL,
		K_CIRCLE,
		K_READ,
		K_NOP
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RDATA,
		ST_DONE
	} state_t;

	// one classified command, bounds inclusive
	typedef struct packed {
		kind_t                      kind;
		logic                       empty;
		logic                       oor;
		logic [XW-1:0]              xlo;
		logic [XW-1:0]              xhi;
		logic [YW-1:0]              ylo;
		logic [YW-1:0]              yhi;
		logic signed [DELTA_W-1:0]  dx0;
		logic signed [DELTA_W-1:0]  dy0;
		logic [SQ_W-1:0]            dx0sq;
		logic [SQ_W-1:0]            dy0sq;
		logic [RR_W-1:0]            rr;
		logic [ADDR_W-1:0]          base0;
		logic [COLOR_W-1:0]         color;
	} cmd_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [COLOR_W-1:0] wdata;
		logic               re;
		logic [ADDR_W-1:0]  raddr;
	} ram_req_t;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// clamp a signed coordinate to 0..hi
	function automatic logic [CFG_W-1:0] clamp_pos(input logic signed [COORD_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		if (v[COORD_W-1]) begin
			r = '0;
		end else if (v[COORD_W-2:0] > (COORD_W-1)'(hi)) begin
			r = hi;
		end else begin
			r = v[CFG_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- design/fcrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/fcrf_front.sv -----
// Command front end: accepts input beats, clamps and classifies them, and works out
// start offsets, squares and row base for the walker. Depends on fcrf_pkg.
module fcrf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// opcode[2:0] x_first[14:3] y_first[26:15] x_second[38:27] y_second[50:39]
	// radius[59:51] color[91:60], zero fill above
	input  logic [fcrf_pkg::IN_W-1:0]     s_tdata,
	input  logic [fcrf_pkg::CFG_W-1:0]    eff_w,
	input  logic [fcrf_pkg::CFG_W-1:0]    eff_h,
	output logic                          q_valid,
	input  logic                          q_ready,
	output fcrf_pkg::cmd_t                q_cmd
);

	fcrf_pkg::opcode_t                    op;
	logic signed [fcrf_pkg::COORD_W-1:0]  xa, ya, xb, yb;
	logic [fcrf_pkg::CFG_W-1:0]           r_in;
	logic [fcrf_pkg::CFG_W-1:0]           rx0, rx1, ry0, ry1;
	logic [fcrf_pkg::CFG_W-1:0]           clo_x, clo_y, chi_x, chi_y;
	logic [fcrf_pkg::CFG_W:0]             chi_x_raw, chi_y_raw;
	logic [fcrf_pkg::CFG_W-1:0]           w_m1, h_m1;

	fcrf_pkg::kind_t                      kind_d;
	logic                                 empty_d, oor_d;
	logic [fcrf_pkg::CFG_W-1:0]           xlo_d, xhi_d, ylo_d, yhi_d;
	logic [fcrf_pkg::COLOR_W-1:0]         color_d;

	logic                                 s1_valid_q;
	fcrf_pkg::kind_t                      kind_s1;
	logic                                 empty_s1, oor_s1;
	logic [fcrf_pkg::CFG_W-1:0]           xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	logic [fcrf_pkg::CFG_W-1:0]           cx_s1, cy_s1, r_s1;
	logic [fcrf_pkg::COLOR_W-1:0]         color_s1;

	logic signed [fcrf_pkg::DELTA_W-1:0]  dx0, dy0;
	logic signed [2*fcrf_pkg::DELTA_W-1:0] dx0sq_full, dy0sq_full;
	logic [2*fcrf_pkg::CFG_W-1:0]         rr_full;
	logic [fcrf_pkg::YW+fcrf_pkg::CFG_W-1:0] base_full;

	logic                                 s2_valid_q;
	fcrf_pkg::cmd_t                       cmd_s2;
	logic                                 advance;

	assign op   = fcrf_pkg::opcode_t'(s_tdata[2:0]);
	assign xa   = s_tdata[14:3];
	assign ya   = s_tdata[26:15];
	assign xb   = s_tdata[38:27];
	assign yb   = s_tdata[50:39];
	assign r_in = s_tdata[59:51];
	assign w_m1 = eff_w - 1'b1;
	assign h_m1 = eff_h - 1'b1;

	always_comb begin
		rx0 = fcrf_pkg::clamp_pos(xa, eff_w);
		rx1 = fcrf_pkg::clamp_pos(xb, eff_w);
		ry0 = fcrf_pkg::clamp_pos(ya, eff_h);
		ry1 = fcrf_pkg::clamp_pos(yb, eff_h);
		// circle box: centre is rx0/ry0, low edge floors at zero, high edge stops at last pixel
		clo_x = (rx0 >= r_in) ? rx0 - r_in : '0;
		clo_y = (ry0 >= r_in) ? ry0 - r_in : '0;
		chi_x_raw = {1'b0, rx0} + {1'b0, r_in};
		chi_y_raw = {1'b0, ry0} + {1'b0, r_in};
		chi_x = (chi_x_raw > {1'b0, w_m1}) ? w_m1 : chi_x_raw[fcrf_pkg::CFG_W-1:0];
		chi_y = (chi_y_raw > {1'b0, h_m1}) ? h_m1 : chi_y_raw[fcrf_pkg::CFG_W-1:0];

		kind_d  = fcrf_pkg::K_NOP;
		empty_d = 1'b0;
		oor_d   = 1'b0;
		xlo_d   = '0;
		xhi_d   = '0;
		ylo_d   = '0;
		yhi_d   = '0;
		color_d = s_tdata[91:60];
		unique case (op)
			fcrf_pkg::OP_CLEAR, fcrf_pkg::OP_BLACK: begin
				kind_d  = fcrf_pkg::K_FILL;
				xhi_d   = w_m1;
				yhi_d   = h_m1;
				color_d = (op == fcrf_pkg::OP_CLEAR) ? '0 : fcrf_pkg::OPAQUE_BLACK;
			end
			fcrf_pkg::OP_RECT: begin
				kind_d  = fcrf_pkg::K_FILL;
				empty_d = (rx1 <= rx0) || (ry1 <= ry0);
				xlo_d   = rx0;
				xhi_d   = rx1 - 1'b1;
				ylo_d   = ry0;
				yhi_d   = ry1 - 1'b1;
			end
			fcrf_pkg::OP_CIRCLE: begin
				kind_d  = fcrf_pkg::K_CIRCLE;
				empty_d = (chi_x < clo_x) || (chi_y < clo_y);
				xlo_d   = clo_x;
				xhi_d   = chi_x;
				ylo_d   = clo_y;
				yhi_d   = chi_y;
			end
			fcrf_pkg::OP_READ: begin
				kind_d = fcrf_pkg::K_READ;
				oor_d  = xa[fcrf_pkg::COORD_W-1] || ya[fcrf_pkg::COORD_W-1]
					|| (xa[fcrf_pkg::COORD_W-2:0] >= (fcrf_pkg::COORD_W-1)'(eff_w))
					|| (ya[fcrf_pkg::COORD_W-2:0] >= (fcrf_pkg::COORD_W-1)'(eff_h));
				xlo_d  = xa[fcrf_pkg::CFG_W-1:0];
				ylo_d  = ya[fcrf_pkg::CFG_W-1:0];
			end
			default: begin
				kind_d = fcrf_pkg::K_NOP;
			end
		endcase
	end

	assign advance  = !s2_valid_q || q_ready;
	assign s_tready = !s1_valid_q || advance;
	assign q_valid  = s2_valid_q;
	assign q_cmd    = cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (advance) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= kind_d;
			empty_s1 <= empty_d;
			oor_s1   <= oor_d;
			xlo_s1   <= xlo_d;
			xhi_s1   <= xhi_d;
			ylo_s1   <= ylo_d;
			yhi_s1   <= yhi_d;
			cx_s1    <= rx0;
			cy_s1    <= ry0;
			r_s1     <= r_in;
			color_s1 <= color_d;
		end
	end

	// offsets of the first pixel from the centre, and their squares
	always_comb begin
		dx0 = $signed({1'b0, xlo_s1}) - $signed({1'b0, cx_s1});
		dy0 = $signed({1'b0, ylo_s1}) - $signed({1'b0, cy_s1});
		dx0sq_full = dx0 * dx0;
		dy0sq_full = dy0 * dy0;
		rr_full    = r_s1 * r_s1;
		base_full  = ylo_s1[fcrf_pkg::YW-1:0] * eff_w;
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			cmd_s2.kind  <= kind_s1;
			cmd_s2.empty <= empty_s1;
			cmd_s2.oor   <= oor_s1;
			cmd_s2.xlo   <= xlo_s1[fcrf_pkg::XW-1:0];
			cmd_s2.xhi   <= xhi_s1[fcrf_pkg::XW-1:0];
			cmd_s2.ylo   <= ylo_s1[fcrf_pkg::YW-1:0];
			cmd_s2.yhi   <= yhi_s1[fcrf_pkg::YW-1:0];
			cmd_s2.dx0   <= dx0;
			cmd_s2.dy0   <= dy0;
			cmd_s2.dx0sq <= dx0sq_full[fcrf_pkg::SQ_W-1:0];
			cmd_s2.dy0sq <= dy0sq_full[fcrf_pkg::SQ_W-1:0];
			cmd_s2.rr    <= rr_full[fcrf_pkg::RR_W-1:0];
			cmd_s2.base0 <= base_full[fcrf_pkg::ADDR_W-1:0];
			cmd_s2.color <= color_s1;
		end
	end

endmodule

// ----- design/fcrf_queue.sv -----
// Short command queue between the front end and the pixel walker.
// Depends on fcrf_pkg.
module fcrf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  fcrf_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output fcrf_pkg::cmd_t pop_cmd
);

	fcrf_pkg::cmd_t               entry_q [fcrf_pkg::QDEPTH];
	logic [fcrf_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [fcrf_pkg::QPTR_W:0]    fill_q;
	logic                         do_push, do_pop;

	assign push_ready = (fill_q != (fcrf_pkg::QPTR_W+1)'(fcrf_pkg::QDEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- design/fcrf_back.sv -----
// Pixel walker: steps through each command's box one pixel a cycle, writes the frame
// store, services reads and holds the result beat. Depends on fcrf_pkg.
module fcrf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  fcrf_pkg::cmd_t                q_cmd,
	input  logic [fcrf_pkg::CFG_W-1:0]    eff_w,
	output fcrf_pkg::ram_req_t            ram_req,
	input  logic [fcrf_pkg::COLOR_W-1:0]  ram_rdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_value[31:0] pixels_written[48:32] out_of_range[49], zero fill above
	output logic [fcrf_pkg::OUT_W-1:0]    m_tdata
);

	fcrf_pkg::state_t                     state_q, state_d;
	fcrf_pkg::cmd_t                       cmd_q;
	logic [fcrf_pkg::XW-1:0]              x_q;
	logic [fcrf_pkg::YW-1:0]              y_q;
	logic [fcrf_pkg::ADDR_W-1:0]          base_q;
	logic signed [fcrf_pkg::DELTA_W-1:0]  dx_q, dy_q;
	logic [fcrf_pkg::SQ_W-1:0]            dx2_q, dy2_q;
	logic [fcrf_pkg::CNT_W-1:0]           count_q;
	logic [fcrf_pkg::COLOR_W-1:0]         rv_q;
	logic                                 oor_q;

	logic                                 out_valid_q;
	logic [fcrf_pkg::COLOR_W-1:0]         out_rv_q;
	logic [fcrf_pkg::CNT_W-1:0]           out_count_q;
	logic                                 out_oor_q;

	logic                                 pop, load_out, hit, row_end, last_px;
	logic [fcrf_pkg::SQ_W:0]              dist_sq;
	logic signed [fcrf_pkg::SQ_W+1:0]     dx2_nx, dy2_nx;

	always_comb begin
		dist_sq = {1'b0, dx2_q} + {1'b0, dy2_q};
		hit     = (cmd_q.kind != fcrf_pkg::K_CIRCLE) || (dist_sq <= cmd_q.rr);
		row_end = (x_q == cmd_q.xhi);
		last_px = row_end && (y_q == cmd_q.yhi);
		// (d+1)^2 = d^2 + 2d + 1
		dx2_nx = $signed({2'b00, dx2_q}) + $signed({{8{dx_q[fcrf_pkg::DELTA_W-1]}}, dx_q, 1'b1});
		dy2_nx = $signed({2'b00, dy2_q}) + $signed({{8{dy_q[fcrf_pkg::DELTA_W-1]}}, dy_q, 1'b1});
	end

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		load_out      = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = base_q + fcrf_pkg::ADDR_W'(x_q);
		ram_req.wdata = cmd_q.color;
		ram_req.re    = 1'b0;
		ram_req.raddr = q_cmd.base0 + fcrf_pkg::ADDR_W'(q_cmd.xlo);
		unique case (state_q)
			fcrf_pkg::ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (q_cmd.kind == fcrf_pkg::K_READ && !q_cmd.oor) begin
						ram_req.re = 1'b1;
						state_d    = fcrf_pkg::ST_RDATA;
					end else if ((q_cmd.kind == fcrf_pkg::K_FILL
							|| q_cmd.kind == fcrf_pkg::K_CIRCLE) && !q_cmd.empty) begin
						state_d = fcrf_pkg::ST_WALK;
					end else begin
						state_d = fcrf_pkg::ST_DONE;
					end
				end
			end
			fcrf_pkg::ST_WALK: begin
				ram_req.we = hit;
				if (last_px) begin
					state_d = fcrf_pkg::ST_DONE;
				end
			end
			fcrf_pkg::ST_RDATA: begin
				state_d = fcrf_pkg::ST_DONE;
			end
			fcrf_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = fcrf_pkg::ST_IDLE;
				end
			end
		endcase
	end

	assign q_ready = (state_q == fcrf_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcrf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= q_cmd;
			x_q     <= q_cmd.xlo;
			y_q     <= q_cmd.ylo;
			base_q  <= q_cmd.base0;
			dx_q    <= q_cmd.dx0;
			dy_q    <= q_cmd.dy0;
			dx2_q   <= q_cmd.dx0sq;
			dy2_q   <= q_cmd.dy0sq;
			count_q <= '0;
			rv_q    <= '0;
			oor_q   <= q_cmd.oor && (q_cmd.kind == fcrf_pkg::K_READ);
		end else if (state_q == fcrf_pkg::ST_WALK) begin
			if (hit) begin
				count_q <= count_q + 1'b1;
			end
			if (row_end) begin
				// wrap to the start of the next row
				x_q    <= cmd_q.xlo;
				y_q    <= y_q + 1'b1;
				base_q <= base_q + fcrf_pkg::ADDR_W'(eff_w);
				dx_q   <= cmd_q.dx0;
				dx2_q  <= cmd_q.dx0sq;
				dy_q   <= dy_q + 1'b1;
				dy2_q  <= dy2_nx[fcrf_pkg::SQ_W-1:0];
			end else begin
				x_q   <= x_q + 1'b1;
				dx_q  <= dx_q + 1'b1;
				dx2_q <= dx2_nx[fcrf_pkg::SQ_W-1:0];
			end
		end else if (state_q == fcrf_pkg::ST_RDATA) begin
			rv_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rv_q    <= rv_q;
			out_count_q <= count_q;
			out_oor_q   <= oor_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_oor_q, out_count_q, out_rv_q};

endmodule

// ----- design/framebuffer_circle_rect_fill.sv -----
// Top level of the framebuffer fill engine: configuration registers, front end,
// command queue, pixel walker and frame store. Depends on fcrf_pkg and all fcrf_ modules.
//
//   channel   role                    beat carries
//   s_*       command in  (stream)    opcode, corners or centre, radius, colour
//   m_*       result out  (stream)    read value, pixel count, out-of-range flag
//   p*        register port (APB)     frame_width at 0x0, frame_height at 0x4
//
// The walker steps through a draw's box pixel by pixel (the whole frame for clear and
// paint); its single frame store write port sets that pace. A read passes through a
// read-data state, and an unused opcode goes straight to the result state. The front
// end and a two-deep queue take up to four further commands meanwhile. A result beat
// held by m_tready low stops the walker at the end of the command after it.
// Reset clears control state only; frame store content is undefined until written.
module framebuffer_circle_rect_fill (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// opcode[2:0] x_first[14:3] y_first[26:15] x_second[38:27] y_second[50:39]
	// radius[59:51] color[91:60], zero fill above
	input  logic [fcrf_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// read_value[31:0] pixels_written[48:32] out_of_range[49], zero fill above
	output logic [fcrf_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	logic [fcrf_pkg::CFG_W-1:0]    width_q, height_q, eff_w, eff_h;
	logic                          cfg_wr;
	logic                          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
	fcrf_pkg::cmd_t                q_in_cmd, q_out_cmd;
	fcrf_pkg::ram_req_t            ram_req;
	logic [fcrf_pkg::COLOR_W-1:0]  ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fcrf_pkg::CFG_W'(256);
			height_q <= fcrf_pkg::CFG_W'(256);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= pwdata[fcrf_pkg::CFG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[fcrf_pkg::CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = 32'(width_q);
			REG_FRAME_HEIGHT: prdata = 32'(height_q);
		endcase
	end

	// zero acts as one, anything above the store size as the maximum
	always_comb begin
		if (width_q == '0) begin
			eff_w = fcrf_pkg::CFG_W'(1);
		end else if (width_q > fcrf_pkg::CFG_W'(fcrf_pkg::MAX_WIDTH)) begin
			eff_w = fcrf_pkg::CFG_W'(fcrf_pkg::MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = fcrf_pkg::CFG_W'(1);
		end else if (height_q > fcrf_pkg::CFG_W'(fcrf_pkg::MAX_HEIGHT)) begin
			eff_h = fcrf_pkg::CFG_W'(fcrf_pkg::MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	fcrf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.q_valid  (q_in_valid),
		.q_ready  (q_in_ready),
		.q_cmd    (q_in_cmd)
	);

	fcrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_in_valid),
		.push_ready (q_in_ready),
		.push_cmd   (q_in_cmd),
		.pop_valid  (q_out_valid),
		.pop_ready  (q_out_ready),
		.pop_cmd    (q_out_cmd)
	);

	fcrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_out_valid),
		.q_ready   (q_out_ready),
		.q_cmd     (q_out_cmd),
		.eff_w     (eff_w),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	fcrf_ram #(
		.WIDTH (fcrf_pkg::COLOR_W),
		.DEPTH (fcrf_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- tb/fill_result_checker.sv -----
// Result checker for the framebuffer fill engine: watches the command, result and
// register channels, keeps its own copy of the frame and compares every result beat.
// Depends on fcrf_pkg for widths, opcodes and the opaque black value.
module fill_result_checker #(
	parameter logic [2:0] WIDTH_ADDR  = 3'h0,
	parameter logic [2:0] HEIGHT_ADDR = 3'h4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	// opcode, x_first, y_first, x_second, y_second, radius, color
	input  logic [fcrf_pkg::IN_W-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// read_value, pixels_written, out_of_range
	input  logic [fcrf_pkg::OUT_W-1:0] m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         pending
);
	import fcrf_pkg::*;

	typedef struct packed {
		logic [31:0] read_value;
		logic [16:0] pixels_written;
		logic        out_of_range;
	} fill_result_t;

	logic [31:0]  frame_copy [0:STORE_DEPTH-1];
	logic [8:0]   width_reg;
	logic [8:0]   height_reg;
	fill_result_t results_due [$];
	fill_result_t want;

	// zero acts as one, anything above the maximum as the maximum
	function automatic int effective_size(input logic [8:0] reg_val, input int max_size);
		if (reg_val == 9'd0)
			return 1;
		if (int'(reg_val) > max_size)
			return max_size;
		return int'(reg_val);
	endfunction

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// apply one command to the frame copy and return the result it must give
	function automatic fill_result_t apply_command(input logic [IN_W-1:0] beat);
		fill_result_t res;
		logic [2:0]   op;
		logic [31:0]  colour;
		logic [31:0]  fill_val;
		int xa, ya, xb, yb, rad, w, h;
		int x0, x1, y0, y1, cx, cy, x, y, i;
		int count;
		res = '0;
		count = 0;
		op = beat[2:0];
		xa = $signed(beat[14:3]);
		ya = $signed(beat[26:15]);
		xb = $signed(beat[38:27]);
		yb = $signed(beat[50:39]);
		rad = int'(beat[59:51]);
		colour = beat[91:60];
		w = effective_size(width_reg, MAX_WIDTH);
		h = effective_size(height_reg, MAX_HEIGHT);
		case (op)
			OP_CLEAR, OP_BLACK: begin
				fill_val = (op == OP_CLEAR) ? 32'h0 : OPAQUE_BLACK;
				for (i = 0; i < w * h; i++)
					frame_copy[i] = fill_val;
				count = w * h;
			end
			OP_RECT: begin
				x0 = clamp_int(xa, 0, w);
				x1 = clamp_int(xb, 0, w);
				y0 = clamp_int(ya, 0, h);
				y1 = clamp_int(yb, 0, h);
				for (y = y0; y < y1; y++)
					for (x = x0; x < x1; x++) begin
						frame_copy[y * w + x] = colour;
						count++;
					end
			end
			OP_CIRCLE: begin
				cx = clamp_int(xa, 0, w);
				cy = clamp_int(ya, 0, h);
				y0 = clamp_int(cy - rad, 0, h);
				y1 = clamp_int(cy + rad, -1, h - 1);
				x0 = clamp_int(cx - rad, 0, w);
				x1 = clamp_int(cx + rad, -1, w - 1);
				for (y = y0; y <= y1; y++)
					for (x = x0; x <= x1; x++)
						if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= rad * rad) begin
							frame_copy[y * w + x] = colour;
							count++;
						end
			end
			OP_READ: begin
				if (xa < 0 || xa >= w || ya < 0 || ya >= h)
					res.out_of_range = 1'b1;
				else
					res.read_value = frame_copy[ya * w + xa];
			end
			default: ;
		endcase
		res.pixels_written = count[16:0];
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 9'd256;
			height_reg = 9'd256;
			results_due.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == WIDTH_ADDR)
					width_reg = pwdata[8:0];
				else if (paddr == HEIGHT_ADDR)
					height_reg = pwdata[8:0];
			end
			if (s_tvalid && s_tready)
				results_due.push_back(apply_command(s_tdata));
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result beat %h with no command outstanding", m_tdata);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("read_value", want.read_value, m_tdata[31:0]);
					check_field("pixels_written", 32'(want.pixels_written), 32'(m_tdata[48:32]));
					check_field("out_of_range", 32'(want.out_of_range), 32'(m_tdata[49]));
				end
			end
		end
		pending = results_due.size();
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for framebuffer_circle_rect_fill: clock, reset, command and register
// stimulus, result back-pressure and the verdict. Depends on fcrf_pkg and fill_result_checker.
module tb;
	import fcrf_pkg::*;

	localparam logic [2:0] WIDTH_ADDR  = 3'h0;
	localparam logic [2:0] HEIGHT_ADDR = 3'h4;
	localparam logic [2:0] OP_RSVD5    = 3'd5;
	localparam logic [2:0] OP_RSVD6    = 3'd6;
	localparam logic [2:0] OP_RSVD7    = 3'd7;
	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam int PHASES          = 10;
	localparam int BEATS_PER_PHASE = 58;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	int                cycle_count = 0;
	int                rx_stall = 0;
	bit                rx_calm = 1'b0;
	bit                tx_calm = 1'b0;
	int                phase_w [PHASES] = '{1, 256, 2, 17, 8, 24, 5, 32, 13, 256};
	int                phase_h [PHASES] = '{1, 2, 256, 9, 23, 16, 1, 12, 31, 1};

	always #5 clk = ~clk;

	framebuffer_circle_rect_fill u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	fill_result_checker #(
		.WIDTH_ADDR  (WIDTH_ADDR),
		.HEIGHT_ADDR (HEIGHT_ADDR)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly near the frame, sometimes anywhere in the 12-bit range
	function automatic logic [11:0] rand_coord(input int span);
		if ($urandom_range(0, 9) == 0)
			return 12'($urandom_range(0, 4095));
		return 12'(int'($urandom_range(0, span + 8)) - 4);
	endfunction

	// enter and leave at a falling edge; valid stays high on return
	task automatic send_command(input logic [2:0] op, input logic [11:0] xa,
			input logic [11:0] ya, input logic [11:0] xb, input logic [11:0] yb,
			input logic [8:0] rad, input logic [31:0] colour);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {4'b0, colour, rad, yb, xb, ya, xa, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// drop valid only when something is still outstanding
	task automatic wait_drain();
		if (pending != 0) begin
			s_tvalid <= 1'b0;
			while (pending != 0) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_command(input int w, input int h);
		int roll;
		int big;
		logic [2:0]  op;
		logic [11:0] xa, ya, xb, yb;
		logic [8:0]  rad;
		roll = $urandom_range(0, 99);
		big = (w > h) ? w : h;
		if (roll < 5)
			op = OP_CLEAR;
		else if (roll < 10)
			op = OP_BLACK;
		else if (roll < 40)
			op = OP_RECT;
		else if (roll < 70)
			op = OP_CIRCLE;
		else if (roll < 95)
			op = OP_READ;
		else
			op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
		xa = rand_coord(w);
		ya = rand_coord(h);
		xb = rand_coord(w);
		yb = rand_coord(h);
		// mostly a well-ordered box, the rest left to chance
		if (op == OP_RECT && $urandom_range(0, 3) != 0) begin
			xb = 12'(int'($signed(xa)) + int'($urandom_range(0, w / 2 + 2)));
			yb = 12'(int'($signed(ya)) + int'($urandom_range(0, h / 2 + 2)));
		end
		if (op == OP_READ && $urandom_range(0, 99) < 85) begin
			xa = 12'($urandom_range(0, w - 1));
			ya = 12'($urandom_range(0, h - 1));
		end
		if ($urandom_range(0, 9) == 0)
			rad = 9'($urandom_range(0, 511));
		else
			rad = 9'($urandom_range(0, big / 2 + 2));
		send_command(op, xa, ya, xb, yb, rad, $urandom());
	endtask

	// result side back-pressure, with calm stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if (!rx_calm && $urandom_range(0, 3) == 0)
				rx_stall = pick_gap();
			if ($urandom_range(0, 199) == 0)
				rx_calm = !rx_calm;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int p;
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full 256x256 frame from reset; the first clear defines every pixel
		send_command(OP_CLEAR, 12'($urandom()), 12'($urandom()), 12'($urandom()),
			12'($urandom()), 9'($urandom()), $urandom());
		send_command(OP_READ, 0, 0, 0, 0, 0, 0);
		send_command(OP_RECT, -2048, -2048, 2047, 2047, 0, 32'hFFFF_FFFF);
		send_command(OP_READ, 255, 255, 0, 0, 0, 0);
		send_command(OP_READ, 2047, 0, 0, 0, 0, 0);
		send_command(OP_READ, 0, -2048, 0, 0, 0, 0);
		send_command(OP_READ, 256, 10, 0, 0, 0, 0);
		send_command(OP_READ, 10, 256, 0, 0, 0, 0);
		send_command(OP_RECT, 40, 30, 10, 60, 0, 32'h0BAD_0BAD);
		send_command(OP_RECT, 10, 20, 13, 22, 0, 32'hA5A5_5A5A);
		send_command(OP_READ, 12, 21, 0, 0, 0, 0);
		send_command(OP_CIRCLE, 0, 0, 0, 0, 0, 32'h1234_5678);
		send_command(OP_CIRCLE, 2047, 2047, 0, 0, 3, 32'h00C0_FFEE);
		send_command(OP_CIRCLE, -2048, 100, 0, 0, 5, 32'h5555_AAAA);
		send_command(OP_CIRCLE, 128, 128, 0, 0, 20, 32'h0F0F_F0F0);
		send_command(OP_READ, 128, 148, 0, 0, 0, 0);
		send_command(OP_READ, 255, 253, 0, 0, 0, 0);
		send_command(OP_RSVD5, 12'($urandom()), 12'($urandom()), 12'($urandom()),
			12'($urandom()), 9'($urandom()), $urandom());
		send_command(OP_RSVD6, 5, 5, 9, 9, 3, $urandom());
		send_command(OP_RSVD7, 12'($urandom()), 12'($urandom()), 12'($urandom()),
			12'($urandom()), 511, $urandom());
		send_command(OP_BLACK, 0, 0, 0, 0, 0, 0);
		send_command(OP_READ, 255, 255, 0, 0, 0, 0);

		// registers outside their range: zero width, height above the maximum
		wait_drain();
		write_reg(WIDTH_ADDR, 32'd0);
		write_reg(HEIGHT_ADDR, 32'd300);
		send_command(OP_RECT, -5, -5, 5, 400, 0, 32'hDEAD_BEEF);
		send_command(OP_CIRCLE, 0, 128, 0, 0, 511, 32'hCAFE_F00D);
		send_command(OP_READ, 0, 255, 0, 0, 0, 0);
		send_command(OP_READ, 1, 0, 0, 0, 0, 0);

		for (p = 0; p < PHASES; p++) begin
			wait_drain();
			write_reg(WIDTH_ADDR, 32'(phase_w[p]));
			write_reg(HEIGHT_ADDR, 32'(phase_h[p]));
			tx_calm = ($urandom_range(0, 2) == 0);
			for (n = 0; n < BEATS_PER_PHASE; n++) begin
				// hold off now and then until every result is back
				if ($urandom_range(0, 49) == 0)
					wait_drain();
				random_command(phase_w[p], phase_h[p]);
			end
		end

		wait_drain();
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
